FILE: design/branch_direction_predictor_defines.svh
`ifndef BRANCH_DIRECTION_PREDICTOR_DEFINES_SVH
`define BRANCH_DIRECTION_PREDICTOR_DEFINES_SVH

// checks that hold in the same cycle
`define BDP_ASSERT_NOW(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checks of the form antecedent then consequent in the next cycle
`define BDP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/bdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdp_pkg;

    localparam int C_LOCAL_PRED_ENTRIES = 2048;
    localparam int C_LOCAL_HIST_ENTRIES = 2048;
    localparam int C_GLOBAL_ENTRIES     = 8192;
    localparam int C_MAX_COUNT_BITS     = 8;

    localparam int C_CTR_W   = 8;
    localparam int C_CFG_W   = 4;
    localparam int C_CFG_IDX_W = 3;
    localparam int C_MASK_W  = 16;

    typedef logic [C_CTR_W-1:0] t_ctr;
    typedef logic [C_CFG_W-1:0] t_cfg;

    localparam logic [1:0] MODE_BIMODAL    = 2'd0;
    localparam logic [1:0] MODE_GSHARE     = 2'd1;
    localparam logic [1:0] MODE_TOURNAMENT = 2'd2;

    localparam logic [C_CFG_IDX_W-1:0] CFG_MODE         = 3'd0;
    localparam logic [C_CFG_IDX_W-1:0] CFG_LOCAL_BITS   = 3'd1;
    localparam logic [C_CFG_IDX_W-1:0] CFG_GLOBAL_BITS  = 3'd2;
    localparam logic [C_CFG_IDX_W-1:0] CFG_CHOICE_BITS  = 3'd3;
    localparam logic [C_CFG_IDX_W-1:0] CFG_LOCAL_PRED   = 3'd4;
    localparam logic [C_CFG_IDX_W-1:0] CFG_LOCAL_HIST   = 3'd5;
    localparam logic [C_CFG_IDX_W-1:0] CFG_GLOBAL_LOG2  = 3'd6;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HIST,
        S_CTR,
        S_UPD
    } t_state;

    typedef struct packed {
        logic pred;
        logic lc_we;
        logic gc_we;
        logic cc_we;
        logic hist_we;
        logic ghist_we;
    } t_upd;

    function automatic int f_flog2(int n);
        int k;
        k = 0;
        for (int j = 1; j <= C_MASK_W; j++) begin
            if ((1 << j) <= n) begin
                k = j;
            end
        end
        return k;
    endfunction

    function automatic logic [C_MASK_W-1:0] f_mask(t_cfg req, logic [4:0] aw);
        logic [4:0]          k;
        logic [C_MASK_W-1:0] m;
        k = ({1'b0, req} > aw) ? aw : {1'b0, req};
        for (int j = 0; j < C_MASK_W; j++) begin
            m[j] = (5'(j) < k);
        end
        return m;
    endfunction

    function automatic t_cfg f_eff_bits(t_cfg b, t_cfg maxb);
        t_cfg e;
        if (b == '0) begin
            e = t_cfg'(1);
        end else if (b > maxb) begin
            e = maxb;
        end else begin
            e = b;
        end
        return e;
    endfunction

    function automatic logic f_ctr_dir(t_ctr c, t_cfg eff);
        logic [2:0] sel;
        sel = eff[2:0] - 3'd1;
        return c[sel];
    endfunction

    function automatic t_ctr f_ctr_train(t_ctr c, t_cfg eff, logic up);
        logic [C_CTR_W:0] maxv;
        t_ctr             r;
        maxv = ((C_CTR_W+1)'(1) << eff) - (C_CTR_W+1)'(1);
        r = c;
        if (up) begin
            if (c < maxv[C_CTR_W-1:0]) begin
                r = c + t_ctr'(1);
            end
        end else if (c != '0) begin
            r = c - t_ctr'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/bdp_decide.sv
`timescale 1ns / 1ps
`default_nettype none

module bdp_decide #(
    parameter int MAX_COUNT_BITS = bdp_pkg::C_MAX_COUNT_BITS
) (
    input  wire logic [1:0]                i_mode,
    input  wire bdp_pkg::t_cfg             i_local_bits,
    input  wire bdp_pkg::t_cfg             i_global_bits,
    input  wire bdp_pkg::t_cfg             i_choice_bits,
    input  wire logic                      i_taken,
    input  wire logic [MAX_COUNT_BITS-1:0] i_lc,
    input  wire logic [MAX_COUNT_BITS-1:0] i_gc,
    input  wire logic [MAX_COUNT_BITS-1:0] i_cc,
    output bdp_pkg::t_upd                  o_ctl,
    output logic [MAX_COUNT_BITS-1:0]      o_lc,
    output logic [MAX_COUNT_BITS-1:0]      o_gc,
    output logic [MAX_COUNT_BITS-1:0]      o_cc
);
    import bdp_pkg::*;

    localparam t_cfg MAXB = t_cfg'(MAX_COUNT_BITS);

    t_cfg le, ge, ce;
    t_ctr lc_x, gc_x, cc_x;
    t_ctr lc_t, gc_t, cc_t;
    logic lpred, gpred, cpred;

    assign le    = f_eff_bits(i_local_bits, MAXB);
    assign ge    = f_eff_bits(i_global_bits, MAXB);
    assign ce    = f_eff_bits(i_choice_bits, MAXB);
    assign lc_x  = t_ctr'(i_lc);
    assign gc_x  = t_ctr'(i_gc);
    assign cc_x  = t_ctr'(i_cc);
    assign lpred = f_ctr_dir(lc_x, le);
    assign gpred = f_ctr_dir(gc_x, ge);
    assign cpred = f_ctr_dir(cc_x, ce);
    assign lc_t  = f_ctr_train(lc_x, le, i_taken);
    assign gc_t  = f_ctr_train(gc_x, ge, i_taken);
    // choice moves toward global when local was wrong
    assign cc_t  = f_ctr_train(cc_x, ce, lpred != i_taken);

    assign o_lc = lc_t[MAX_COUNT_BITS-1:0];
    assign o_gc = gc_t[MAX_COUNT_BITS-1:0];
    assign o_cc = cc_t[MAX_COUNT_BITS-1:0];

    always_comb begin
        o_ctl = '0;
        unique case (i_mode)
            MODE_BIMODAL: begin
                o_ctl.pred  = lpred;
                o_ctl.lc_we = 1'b1;
            end
            MODE_GSHARE: begin
                o_ctl.pred     = gpred;
                o_ctl.gc_we    = 1'b1;
                o_ctl.ghist_we = 1'b1;
            end
            MODE_TOURNAMENT: begin
                o_ctl.pred     = cpred ? gpred : lpred;
                o_ctl.lc_we    = 1'b1;
                o_ctl.gc_we    = 1'b1;
                o_ctl.cc_we    = (lpred != gpred);
                o_ctl.hist_we  = 1'b1;
                o_ctl.ghist_we = 1'b1;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/branch_direction_predictor.sv
`timescale 1ns / 1ps
`default_nettype none
`include "branch_direction_predictor_defines.svh"

// Branch direction predictor (bimodal, gshare or tournament). Pulse start with a resolved
// branch while busy is low; the prediction made before training and its correctness come
// back on o_predicted / o_correct with o_valid high for exactly one cycle, in S_UPD after
// the transfer passes S_HIST and S_CTR; the receiver cannot stall them. A new branch is
// taken in that result cycle, so the next one can be accepted while the last is written
// back: the local history read (S_HIST), the dependent counter read (S_CTR) and the write
// back (S_UPD) follow one another on the tables. After reset and after every configuration
// write to a valid index the tables are swept to zero, one entry per cycle over the deepest
// table; busy stays high during the sweep while configuration writes are still taken.
module branch_direction_predictor #(
    parameter int LOCAL_PRED_ENTRIES = bdp_pkg::C_LOCAL_PRED_ENTRIES,
    parameter int LOCAL_HIST_ENTRIES = bdp_pkg::C_LOCAL_HIST_ENTRIES,
    parameter int GLOBAL_ENTRIES     = bdp_pkg::C_GLOBAL_ENTRIES,
    parameter int MAX_COUNT_BITS     = bdp_pkg::C_MAX_COUNT_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [63:0]                  i_pc,
    input  wire logic                         i_taken,
    input  wire logic                         i_cfg_we,
    input  wire logic [bdp_pkg::C_CFG_IDX_W-1:0] i_cfg_index,
    input  wire bdp_pkg::t_cfg                i_cfg_data,
    output logic                              o_valid,
    output logic                              o_predicted,
    output logic                              o_correct
);
    import bdp_pkg::*;

    localparam int LPAW    = f_flog2(LOCAL_PRED_ENTRIES);
    localparam int LHAW    = f_flog2(LOCAL_HIST_ENTRIES);
    localparam int GAW     = f_flog2(GLOBAL_ENTRIES);
    localparam int LPAW_ST = (LPAW < 1) ? 1 : LPAW;
    localparam int LHAW_ST = (LHAW < 1) ? 1 : LHAW;
    localparam int GAW_ST  = (GAW < 1) ? 1 : GAW;
    localparam int CLR_AW1 = (LPAW_ST > LHAW_ST) ? LPAW_ST : LHAW_ST;
    localparam int CLR_AW  = (CLR_AW1 > GAW_ST) ? CLR_AW1 : GAW_ST;
    localparam int CW      = MAX_COUNT_BITS;

    t_state r_state, n_state;

    logic [1:0] r_mode;
    t_cfg       r_local_bits, r_global_bits, r_choice_bits;
    t_cfg       r_lp_log2, r_lh_log2, r_g_log2;

    logic [CLR_AW-1:0] r_clr, n_clr;
    logic [GAW_ST-1:0] r_ghist, n_ghist;
    logic [63:0]       r_pc;
    logic              r_taken;

    logic [CW-1:0]      mem_lc [0:(2**LPAW_ST)-1];
    logic [LPAW_ST-1:0] mem_lh [0:(2**LHAW_ST)-1];
    logic [CW-1:0]      mem_gc [0:(2**GAW_ST)-1];
    logic [CW-1:0]      mem_cc [0:(2**GAW_ST)-1];

    logic [CW-1:0]      r_lc_q, r_gc_q, r_cc_q;
    logic [LPAW_ST-1:0] r_hist_q;

    logic [C_MASK_W-1:0] lp_mask_f, lh_mask_f, g_mask_f;
    logic [LPAW_ST-1:0]  lp_mask;
    logic [LHAW_ST-1:0]  lh_mask;
    logic [GAW_ST-1:0]   g_mask;

    logic [LHAW_ST-1:0] lh_addr;
    logic [LPAW_ST-1:0] lc_addr;
    logic [GAW_ST-1:0]  gc_addr;
    logic [LPAW_ST-1:0] hist_new;

    logic cfg_hit, accept, clearing, in_upd;

    t_upd          ctl;
    logic [CW-1:0] lc_new, gc_new, cc_new;

    logic               lc_we, lh_we, gc_we, cc_we;
    logic [LPAW_ST-1:0] lc_waddr;
    logic [LHAW_ST-1:0] lh_waddr;
    logic [GAW_ST-1:0]  g_waddr;
    logic [CW-1:0]      lc_wdata, gc_wdata, cc_wdata;
    logic [LPAW_ST-1:0] lh_wdata;

    assign cfg_hit  = i_cfg_we && (i_cfg_index <= CFG_GLOBAL_LOG2);
    assign accept   = start && !busy;
    assign clearing = (r_state == S_CLEAR);
    assign in_upd   = (r_state == S_UPD);

    // effective index masks
    assign lp_mask_f = f_mask(r_lp_log2, 5'(LPAW));
    assign lh_mask_f = f_mask(r_lh_log2, 5'(LHAW));
    assign g_mask_f  = f_mask(r_g_log2, 5'(GAW));
    assign lp_mask   = lp_mask_f[LPAW_ST-1:0];
    assign lh_mask   = lh_mask_f[LHAW_ST-1:0];
    assign g_mask    = g_mask_f[GAW_ST-1:0];

    assign lh_addr = r_pc[2 +: LHAW_ST] & lh_mask;
    assign lc_addr = (r_mode == MODE_BIMODAL) ? (r_pc[2 +: LPAW_ST] & lp_mask)
                                              : (r_hist_q & lp_mask);
    assign gc_addr = (r_mode == MODE_GSHARE) ? ((r_ghist ^ r_pc[GAW_ST-1:0]) & g_mask)
                                             : (r_ghist & g_mask);
    assign hist_new = ((r_hist_q << 1) | LPAW_ST'(r_taken)) & lp_mask;

    bdp_decide #(
        .MAX_COUNT_BITS(MAX_COUNT_BITS)
    ) u_decide (
        .i_mode        (r_mode),
        .i_local_bits  (r_local_bits),
        .i_global_bits (r_global_bits),
        .i_choice_bits (r_choice_bits),
        .i_taken       (r_taken),
        .i_lc          (r_lc_q),
        .i_gc          (r_gc_q),
        .i_cc          (r_cc_q),
        .o_ctl         (ctl),
        .o_lc          (lc_new),
        .o_gc          (gc_new),
        .o_cc          (cc_new)
    );

    // write ports: clear sweep or update
    assign lc_we    = clearing || (in_upd && ctl.lc_we);
    assign lh_we    = clearing || (in_upd && ctl.hist_we);
    assign gc_we    = clearing || (in_upd && ctl.gc_we);
    assign cc_we    = clearing || (in_upd && ctl.cc_we);
    assign lc_waddr = clearing ? r_clr[LPAW_ST-1:0] : lc_addr;
    assign lh_waddr = clearing ? r_clr[LHAW_ST-1:0] : lh_addr;
    assign g_waddr  = clearing ? r_clr[GAW_ST-1:0] : gc_addr;
    assign lc_wdata = clearing ? '0 : lc_new;
    assign gc_wdata = clearing ? '0 : gc_new;
    assign cc_wdata = clearing ? '0 : cc_new;
    assign lh_wdata = clearing ? '0 : hist_new;

    always_ff @(posedge i_clk) begin
        if (lc_we) begin
            mem_lc[lc_waddr] <= lc_wdata;
        end
        r_lc_q <= mem_lc[lc_addr];
    end

    always_ff @(posedge i_clk) begin
        if (lh_we) begin
            mem_lh[lh_waddr] <= lh_wdata;
        end
        r_hist_q <= mem_lh[lh_addr];
    end

    always_ff @(posedge i_clk) begin
        if (gc_we) begin
            mem_gc[g_waddr] <= gc_wdata;
        end
        r_gc_q <= mem_gc[gc_addr];
    end

    always_ff @(posedge i_clk) begin
        if (cc_we) begin
            mem_cc[g_waddr] <= cc_wdata;
        end
        r_cc_q <= mem_cc[gc_addr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        if (cfg_hit) begin
            n_state = S_CLEAR;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr == '1) begin
                        n_state = S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        n_state = S_HIST;
                    end
                end
                S_HIST: n_state = S_CTR;
                S_CTR:  n_state = S_UPD;
                S_UPD: begin
                    n_state = start ? S_HIST : S_IDLE;
                end
                default: n_state = S_CLEAR;
            endcase
        end
    end

    // outputs
    always_comb begin
        busy        = 1'b1;
        o_valid     = 1'b0;
        o_predicted = 1'b0;
        o_correct   = 1'b0;
        unique case (r_state)
            S_IDLE: busy = 1'b0;
            S_UPD: begin
                busy        = 1'b0;
                o_valid     = 1'b1;
                o_predicted = ctl.pred;
                o_correct   = (ctl.pred == r_taken);
            end
            default: busy = 1'b1;
        endcase
    end

    always_comb begin
        n_clr   = clearing ? (r_clr + CLR_AW'(1)) : r_clr;
        n_ghist = r_ghist;
        if (cfg_hit) begin
            n_clr   = '0;
            n_ghist = '0;
        end else if (in_upd && ctl.ghist_we) begin
            n_ghist = ((r_ghist << 1) | GAW_ST'(r_taken)) & g_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_ghist       <= '0;
            r_mode        <= MODE_TOURNAMENT;
            r_local_bits  <= t_cfg'(2);
            r_global_bits <= t_cfg'(2);
            r_choice_bits <= t_cfg'(2);
            r_lp_log2     <= t_cfg'(11);
            r_lh_log2     <= t_cfg'(11);
            r_g_log2      <= t_cfg'(13);
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ghist <= n_ghist;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MODE:        r_mode        <= i_cfg_data[1:0];
                    CFG_LOCAL_BITS:  r_local_bits  <= i_cfg_data;
                    CFG_GLOBAL_BITS: r_global_bits <= i_cfg_data;
                    CFG_CHOICE_BITS: r_choice_bits <= i_cfg_data;
                    CFG_LOCAL_PRED:  r_lp_log2     <= i_cfg_data;
                    CFG_LOCAL_HIST:  r_lh_log2     <= i_cfg_data;
                    CFG_GLOBAL_LOG2: r_g_log2      <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pc    <= i_pc;
            r_taken <= i_taken;
        end
    end

    `BDP_ASSERT_NOW(a_upd_after_ctr, (r_state == S_UPD) |-> ($past(r_state) == S_CTR), "result without counter read")
    `BDP_ASSERT_NEXT(a_cfg_clears, cfg_hit, (r_state == S_CLEAR) && (r_clr == '0) && (r_ghist == '0), "config write did not restart clear")
    `BDP_ASSERT_NEXT(a_accept_reads, accept && !cfg_hit, r_state == S_HIST, "transfer did not start a history read")
    `BDP_ASSERT_NOW(a_ghist_masked, (r_ghist & ~g_mask) == '0, "global history outside index mask")
    `BDP_ASSERT_NOW(a_unused_mode, (o_valid && (r_mode != MODE_BIMODAL) && (r_mode != MODE_GSHARE) && (r_mode != MODE_TOURNAMENT)) |-> !o_predicted, "unused mode predicted taken")

endmodule

`default_nettype wire
